### hw/rtl/icdl_pkg.sv
// Shared types and codes for the idle connection deadline list.
// Used by the top level; has no dependencies of its own.
package icdl_pkg;

  // Command codes carried on the input tuser.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  // Upper bound on expired entries reported by a single poll.
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/icdl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module icdl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/idle_connection_deadline_list_top.sv
// Top level of the idle connection deadline list.
// Depends on icdl_pkg and icdl_ram.
// The block keeps up to TABLE_DEPTH connections sorted by deadline in one RAM
// that is used as a ring: head_q points at the earliest entry, so expired
// entries leave from the front without any data movement.
// Input channel (s_axis): tuser carries the command, tdata the connection id,
// the timeout and the current time. A transaction is taken only while idle.
// Output channel (m_axis): tuser carries the result kind, tdata the id, and
// tlast marks the final result caused by an input transaction. Insert, remove
// and unused commands give one result; a poll gives one result per expired
// entry (at most 16, earliest first) or a single "none expired" result.
// Sequence: insert, remove and poll first scan the valid entries through the RAM
// read port (SCAN). Unless an insert finds the table full or a remove finds no
// such id, both then move the entries between the old and the new position
// (SHIFT); an insert then writes the new entry (WRNEW), and the response is
// given in RESP. A poll reads each expired entry (EMRD) and hands it to the
// output register (EMWT); an unused command goes straight to RESP.
// A result waits in an output register; while the receiver stalls, the next
// transaction is still taken and its first result waits for the register.
// Reset empties the table at once (count and head cleared).
module idle_connection_deadline_list_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] conn_id, [31:16] timeout_seconds, [63:32] now
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] expired_id
  output logic [15:0] m_axis_tdata_o,
  // [1:0] result_kind
  output logic [1:0]  m_axis_tuser_o,
  // last
  output logic        m_axis_tlast_o
);

  import icdl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_WRNEW = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;
  localparam logic [2:0] ST_EMRD  = 3'd5;
  localparam logic [2:0] ST_EMWT  = 3'd6;

  // Logical position in the sorted list to RAM address, wrapping at the depth.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(l);
    if (s >= (CW+1)'(TABLE_DEPTH)) begin
      s = s - (CW+1)'(TABLE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  // Control state.
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] head_q, head_d;
  logic          pv_q, pv_d;
  logic          ov_q, ov_d;

  // Working registers of the current transaction.
  logic [1:0]    cmd_q, cmd_d;
  logic [15:0]   id_q, id_d;
  logic [31:0]   key_q, key_d;
  logic [1:0]    rkind_q, rkind_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] left_q, left_d;
  logic          up_q, up_d;
  logic [CW-1:0] pidx_q, pidx_d;
  logic          found_q, found_d;
  logic [CW-1:0] m_q, m_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] n_q, n_d;

  // Output register.
  logic [1:0]    okind_q, okind_d;
  logic [15:0]   oid_q, oid_d;
  logic          olast_q, olast_d;

  // RAM port signals.
  logic          ram_re, ram_we;
  logic [IW-1:0] ram_raddr, ram_waddr;
  entry_t        ram_wdata, ram_rdata;

  logic          in_acc, out_free;
  logic [32:0]   dl_sum;
  logic [31:0]   dl_sat;

  icdl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ov_q || m_axis_tready_i;

  // New deadline, saturating on overflow.
  assign dl_sum = {1'b0, s_axis_tdata_i[63:32]} + {17'd0, s_axis_tdata_i[31:16]};
  assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    pv_d      = pv_q;
    ov_d      = ov_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    key_d     = key_q;
    rkind_d   = rkind_q;
    rd_idx_d  = rd_idx_q;
    left_d    = left_q;
    up_d      = up_q;
    pidx_d    = pidx_q;
    found_d   = found_q;
    m_d       = m_q;
    p_d       = p_q;
    n_d       = n_q;
    okind_d   = okind_q;
    oid_d     = oid_q;
    olast_d   = olast_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = phys(head_q, rd_idx_q);
    ram_waddr = phys(head_q, p_q);
    ram_wdata = '{id: id_q, deadline: key_q};

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d    = s_axis_tuser_i;
          id_d     = s_axis_tdata_i[15:0];
          key_d    = (s_axis_tuser_i == CMD_INSERT) ? dl_sat : s_axis_tdata_i[63:32];
          rd_idx_d = '0;
          pv_d     = 1'b0;
          found_d  = 1'b0;
          m_d      = cnt_q;
          p_d      = '0;
          n_d      = '0;
          rkind_d  = KIND_ACK;
          if (s_axis_tuser_i == CMD_INSERT || s_axis_tuser_i == CMD_REMOVE ||
              s_axis_tuser_i == CMD_POLL) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the data comes back in the next cycle.
        if (rd_idx_q != cnt_q) begin
          ram_re   = 1'b1;
          pv_d     = 1'b1;
          pidx_d   = rd_idx_q;
          rd_idx_d = rd_idx_q + CW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (cmd_q == CMD_POLL) begin
            // Expired entries form a prefix of the sorted list.
            if (ram_rdata.deadline <= key_q && 32'(n_q) < MAX_RESULTS) begin
              n_d = n_q + CW'(1);
            end
          end else if (ram_rdata.id == id_q) begin
            found_d = 1'b1;
            m_d     = pidx_q;
          end else if (cmd_q == CMD_INSERT && ram_rdata.deadline < key_q) begin
            p_d = p_q + CW'(1);
          end
        end
        if (rd_idx_q == cnt_q && !pv_q) begin
          case (cmd_q)
            CMD_INSERT: begin
              if (!found_q && cnt_q == CW'(TABLE_DEPTH)) begin
                rkind_d = KIND_FULL;
                state_d = ST_RESP;
              end else begin
                // The old copy (or the end of the list) sits at m, the new
                // entry goes to p: move what lies between by one place.
                if (p_q <= m_q) begin
                  up_d     = 1'b1;
                  rd_idx_d = m_q - CW'(1);
                  left_d   = m_q - p_q;
                end else begin
                  up_d     = 1'b0;
                  rd_idx_d = m_q + CW'(1);
                  left_d   = p_q - m_q;
                end
                if (!found_q) begin
                  cnt_d = cnt_q + CW'(1);
                end
                state_d = ST_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (found_q) begin
                up_d     = 1'b0;
                rd_idx_d = m_q + CW'(1);
                left_d   = cnt_q - CW'(1) - m_q;
                cnt_d    = cnt_q - CW'(1);
                state_d  = ST_SHIFT;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              if (n_q == '0) begin
                rkind_d = KIND_NONE;
                state_d = ST_RESP;
              end else begin
                rd_idx_d = '0;
                state_d  = ST_EMRD;
              end
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Read one entry per cycle and write it back one place over in the
        // next cycle; the read and write addresses never coincide.
        if (left_q != '0) begin
          ram_re   = 1'b1;
          pv_d     = 1'b1;
          pidx_d   = rd_idx_q;
          rd_idx_d = up_q ? rd_idx_q - CW'(1) : rd_idx_q + CW'(1);
          left_d   = left_q - CW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, up_q ? pidx_q + CW'(1) : pidx_q - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (left_q == '0 && !pv_q) begin
          state_d = (cmd_q == CMD_INSERT) ? ST_WRNEW : ST_RESP;
        end
      end

      ST_WRNEW: begin
        ram_we  = 1'b1;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = rkind_q;
          oid_d   = id_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_EMRD: begin
        ram_re  = 1'b1;
        state_d = ST_EMWT;
      end

      ST_EMWT: begin
        // Read data holds here while the receiver stalls.
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_EXPIRED;
          oid_d   = ram_rdata.id;
          olast_d = (rd_idx_q + CW'(1) == n_q);
          if (rd_idx_q + CW'(1) == n_q) begin
            head_d  = phys(head_q, n_q);
            cnt_d   = cnt_q - n_q;
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
            state_d  = ST_EMRD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      head_q  <= '0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    key_q    <= key_d;
    rkind_q  <= rkind_d;
    rd_idx_q <= rd_idx_d;
    left_q   <= left_d;
    up_q     <= up_d;
    pidx_q   <= pidx_d;
    found_q  <= found_d;
    m_q      <= m_d;
    p_q      <= p_d;
    n_q      <= n_d;
    okind_q  <= okind_d;
    oid_q    <= oid_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = oid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTH
  // The fill count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // The ring head stays inside the RAM.
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < TABLE_DEPTH)
    else $error("head pointer out of range");

  // The table is only written while entries are moved or the new one is placed.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SHIFT || state_q == ST_WRNEW))
    else $error("RAM write outside of an update phase");

  // Every result other than an expired entry ends its transaction.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KIND_EXPIRED) |-> m_axis_tlast_o)
    else $error("single result without tlast");
`endif

endmodule
